@@ src/ittp_pkg.sv @@
// ----------------------------------------------------------------------------
// ittp_pkg
// Shared types, codes and helper functions for the infix to postfix converter.
// ----------------------------------------------------------------------------
package ittp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        K_MUL  = 3'd0,
        K_DIV  = 3'd1,
        K_ADD  = 3'd2,
        K_SUB  = 3'd3,
        K_PAR  = 3'd4,
        K_BRK  = 3'd5,
        K_BRC  = 3'd6,
        K_NONE = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CL_OPERAND,
        CL_OPERATOR,
        CL_OPEN,
        CL_CLOSE
    } cls_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNMATCHED = 2'd2,
        ST_UNCLOSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RELOAD
    } state_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_FLUSH,
        PH_END
    } phase_t;

    typedef struct packed {
        cls_t       cls;
        kind_t      kind;
        logic [7:0] sym;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       sv;
        status_t    status;
    } res_t;

    function automatic logic [7:0] kind_char(kind_t k);
        logic [7:0] c;
        unique case (k)
            K_MUL:   c = 8'h2A;
            K_DIV:   c = 8'h2F;
            K_ADD:   c = 8'h2B;
            K_SUB:   c = 8'h2D;
            K_PAR:   c = 8'h28;
            K_BRK:   c = 8'h5B;
            K_BRC:   c = 8'h7B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] prec_of(kind_t k);
        logic [1:0] p;
        unique case (k)
            K_MUL, K_DIV: p = 2'd2;
            K_ADD, K_SUB: p = 2'd1;
            default:      p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic cmd_t classify(logic [7:0] s, logic last);
        cmd_t c;
        c.sym  = s;
        c.last = last;
        unique case (s)
            8'h2A:   begin c.cls = CL_OPERATOR; c.kind = K_MUL;  end
            8'h2F:   begin c.cls = CL_OPERATOR; c.kind = K_DIV;  end
            8'h2B:   begin c.cls = CL_OPERATOR; c.kind = K_ADD;  end
            8'h2D:   begin c.cls = CL_OPERATOR; c.kind = K_SUB;  end
            8'h28:   begin c.cls = CL_OPEN;     c.kind = K_PAR;  end
            8'h5B:   begin c.cls = CL_OPEN;     c.kind = K_BRK;  end
            8'h7B:   begin c.cls = CL_OPEN;     c.kind = K_BRC;  end
            8'h29:   begin c.cls = CL_CLOSE;    c.kind = K_PAR;  end
            8'h5D:   begin c.cls = CL_CLOSE;    c.kind = K_BRK;  end
            8'h7D:   begin c.cls = CL_CLOSE;    c.kind = K_BRC;  end
            default: begin c.cls = CL_OPERAND;  c.kind = K_NONE; end
        endcase
        return c;
    endfunction

endpackage

@@ src/ittp_expr_if.sv @@
// ----------------------------------------------------------------------------
// ittp_expr_if
// Infix character channel: one expression character per transfer.
// ----------------------------------------------------------------------------
interface ittp_expr_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expr;

    modport source (output valid, output symbol, output end_of_expr, input ready);
    modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

@@ src/ittp_post_if.sv @@
// ----------------------------------------------------------------------------
// ittp_post_if
// Postfix result channel: one character or status item per transfer.
// ----------------------------------------------------------------------------
interface ittp_post_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output out_symbol, output symbol_valid,
                    output status, output run_last, input ready);
    modport sink   (input valid, input out_symbol, input symbol_valid,
                    input status, input run_last, output ready);
endinterface

@@ src/ittp_ram.sv @@
// ----------------------------------------------------------------------------
// ittp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ittp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ittp_front.sv @@
// ----------------------------------------------------------------------------
// ittp_front
// Accepts expression characters, classifies them and queues the commands.
// ----------------------------------------------------------------------------
module ittp_front (
    input  logic              clk,
    input  logic              rst_n,
    ittp_expr_if.sink         expr,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ittp_pkg::cmd_t    cmd
);

    ittp_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push;
    logic           pop;

    assign expr.ready = (cnt_reg != 2'd2);
    assign push       = expr.valid && expr.ready;
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= ittp_pkg::classify(expr.symbol, expr.end_of_expr);
        end
    end

endmodule

@@ src/ittp_back.sv @@
// ----------------------------------------------------------------------------
// ittp_back
// Operator stack sequencer: pops, pushes and flushes, and stages results so
// the last one of each character can be marked.
// ----------------------------------------------------------------------------
module ittp_back #(
    parameter int STACK_DEPTH = ittp_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ittp_pkg::cmd_t    cmd,
    ittp_post_if.source       postfix
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    ittp_pkg::state_t state_reg;
    ittp_pkg::state_t state_next;
    ittp_pkg::phase_t phase_reg;
    ittp_pkg::phase_t phase_next;
    ittp_pkg::cmd_t   cmd_reg;
    ittp_pkg::kind_t  top_reg;
    ittp_pkg::kind_t  top_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    ittp_pkg::res_t   pend_reg;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ittp_pkg::res_t   out_res_reg;
    logic             out_last_reg;

    logic             emit;
    ittp_pkg::res_t   emit_res;
    logic             pop;
    logic             push;
    logic             main_done;
    logic             flush_done;
    logic             fin;
    logic             stall;
    logic             exec;
    logic             emit_fire;
    logic             pop_fire;
    logic             push_fire;
    logic             fin_fire;
    logic             out_free;
    logic             full;
    logic             load;

    logic [AW-1:0]    raddr;
    logic [2:0]       rdata;

    assign out_free  = !out_valid_reg || postfix.ready;
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign exec      = (state_reg == ittp_pkg::S_EXEC);
    assign cmd_ready = (state_reg == ittp_pkg::S_IDLE);
    assign load      = cmd_valid && cmd_ready;

    always_comb
    begin
        emit       = 1'b0;
        emit_res   = '{sym: 8'h00, sv: 1'b0, status: ittp_pkg::ST_OK};
        pop        = 1'b0;
        push       = 1'b0;
        main_done  = 1'b0;
        flush_done = 1'b0;
        fin        = 1'b0;
        if (exec)
        begin
            unique case (phase_reg)
                ittp_pkg::PH_MAIN:
                begin
                    unique case (cmd_reg.cls)
                        ittp_pkg::CL_OPERATOR:
                        begin
                            if (count_reg != '0 && top_reg <= ittp_pkg::K_SUB &&
                                ittp_pkg::prec_of(top_reg) >= ittp_pkg::prec_of(cmd_reg.kind))
                            begin
                                emit     = 1'b1;
                                emit_res = '{sym: ittp_pkg::kind_char(top_reg), sv: 1'b1,
                                             status: ittp_pkg::ST_OK};
                                pop      = 1'b1;
                            end
                            else if (full)
                            begin
                                emit      = 1'b1;
                                emit_res  = '{sym: 8'h00, sv: 1'b0, status: ittp_pkg::ST_FULL};
                                main_done = 1'b1;
                            end
                            else
                            begin
                                push      = 1'b1;
                                main_done = 1'b1;
                            end
                        end
                        ittp_pkg::CL_OPEN:
                        begin
                            if (full)
                            begin
                                emit     = 1'b1;
                                emit_res = '{sym: 8'h00, sv: 1'b0, status: ittp_pkg::ST_FULL};
                            end
                            else
                            begin
                                push = 1'b1;
                            end
                            main_done = 1'b1;
                        end
                        ittp_pkg::CL_CLOSE:
                        begin
                            priority if (count_reg == '0)
                            begin
                                emit      = 1'b1;
                                emit_res  = '{sym: 8'h00, sv: 1'b0,
                                              status: ittp_pkg::ST_UNMATCHED};
                                main_done = 1'b1;
                            end
                            else if (top_reg == cmd_reg.kind)
                            begin
                                pop       = 1'b1;
                                main_done = 1'b1;
                            end
                            else if (top_reg >= ittp_pkg::K_PAR)
                            begin
                                emit      = 1'b1;
                                emit_res  = '{sym: 8'h00, sv: 1'b0,
                                              status: ittp_pkg::ST_UNMATCHED};
                                main_done = 1'b1;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                emit_res = '{sym: ittp_pkg::kind_char(top_reg), sv: 1'b1,
                                             status: ittp_pkg::ST_OK};
                                pop      = 1'b1;
                            end
                        end
                        ittp_pkg::CL_OPERAND:
                        begin
                            emit      = 1'b1;
                            emit_res  = '{sym: cmd_reg.sym, sv: 1'b1, status: ittp_pkg::ST_OK};
                            main_done = 1'b1;
                        end
                        default:
                        begin
                            main_done = 1'b1;
                        end
                    endcase
                end
                ittp_pkg::PH_FLUSH:
                begin
                    if (count_reg == '0)
                    begin
                        flush_done = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        pop  = 1'b1;
                        if (top_reg >= ittp_pkg::K_PAR)
                        begin
                            emit_res = '{sym: 8'h00, sv: 1'b0, status: ittp_pkg::ST_UNCLOSED};
                        end
                        else
                        begin
                            emit_res = '{sym: ittp_pkg::kind_char(top_reg), sv: 1'b1,
                                         status: ittp_pkg::ST_OK};
                        end
                    end
                end
                ittp_pkg::PH_END:
                begin
                    fin = 1'b1;
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    assign stall     = (emit && pend_valid_reg && !out_free) ||
                       (fin && pend_valid_reg && !out_free);
    assign emit_fire = emit && !stall;
    assign pop_fire  = pop && !stall;
    assign push_fire = push && !stall;
    assign fin_fire  = fin && !stall;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ittp_pkg::S_IDLE:
            begin
                if (load)
                begin
                    state_next = ittp_pkg::S_EXEC;
                    phase_next = ittp_pkg::PH_MAIN;
                end
            end
            ittp_pkg::S_EXEC:
            begin
                if (!stall)
                begin
                    if (main_done)
                    begin
                        phase_next = cmd_reg.last ? ittp_pkg::PH_FLUSH : ittp_pkg::PH_END;
                    end
                    if (flush_done)
                    begin
                        phase_next = ittp_pkg::PH_END;
                    end
                    if (fin_fire)
                    begin
                        state_next = ittp_pkg::S_IDLE;
                    end
                    else if (pop_fire && count_reg > CW'(1))
                    begin
                        state_next = ittp_pkg::S_RELOAD;
                    end
                end
            end
            ittp_pkg::S_RELOAD:
            begin
                state_next = ittp_pkg::S_EXEC;
            end
            default:
            begin
                state_next = ittp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (push_fire)
        begin
            count_next = count_reg + CW'(1);
            top_next   = cmd_reg.kind;
        end
        else if (pop_fire)
        begin
            count_next = count_reg - CW'(1);
        end
        if (state_reg == ittp_pkg::S_RELOAD)
        begin
            top_next = ittp_pkg::kind_t'(rdata);
        end
    end

    assign raddr = AW'(count_reg - CW'(2));

    ittp_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_fire),
        .waddr (AW'(count_reg)),
        .wdata (cmd_reg.kind),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (emit_fire)
        begin
            pend_valid_next = 1'b1;
        end
        else if (fin_fire)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = pend_valid_reg && (emit_fire || fin_fire);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ittp_pkg::S_IDLE;
            phase_reg      <= ittp_pkg::PH_MAIN;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (load)
        begin
            cmd_reg <= cmd;
        end
        if (emit_fire)
        begin
            pend_reg <= emit_res;
        end
        if (out_free && pend_valid_reg && (emit_fire || fin_fire))
        begin
            out_res_reg  <= pend_reg;
            out_last_reg <= fin_fire;
        end
    end

    assign postfix.valid        = out_valid_reg;
    assign postfix.out_symbol   = out_res_reg.sym;
    assign postfix.symbol_valid = out_res_reg.sv;
    assign postfix.status       = out_res_reg.status;
    assign postfix.run_last     = out_last_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |-> count_reg != '0)
        else $error("pop from empty stack");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire |-> !full)
        else $error("push into full stack");

    a_reload_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ittp_pkg::S_RELOAD |-> $past(pop_fire))
        else $error("stack reload without pop");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> !pend_valid_reg && state_reg == ittp_pkg::S_IDLE)
        else $error("staged result left after finish");

endmodule

@@ src/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters and
// error status items out.
// ----------------------------------------------------------------------------
// Timing: a character enters the command queue at its transfer and the stack
//   sequencer loads it only when idle; each result is staged in its step and
//   reaches the output register with the next result or the finish step of
//   its character.
// Steps: a load, a main step and a finish step per character, plus a step per
//   entry popped ahead of the main step or by the end-marker flush, plus a step
//   to close the flush, plus a reload step for each pop that leaves the stack
//   non-empty (registered read of the new top); output stalls add to this.
// Reset: stack count, queue and output valid clear; stack RAM is not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = ittp_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ittp_expr_if.sink   expr,
    ittp_post_if.source postfix
);

    logic           cmd_valid;
    logic           cmd_ready;
    ittp_pkg::cmd_t cmd;

    ittp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .expr      (expr),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ittp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .postfix   (postfix)
    );

endmodule
